/* hw/rtl/pxcd_pkg.sv */
// shared constants, codes and types of the pixel format converter and decimator
package pxcd_pkg;

	// largest frame size or sample step
	localparam int unsigned MAX_DIMENSION = 4096;
	// position counter width and clamped dimension width
	localparam int unsigned DIM_W  = $clog2(MAX_DIMENSION);
	localparam int unsigned SIZE_W = DIM_W + 1;
	// width of the size registers on the configuration port
	localparam int unsigned CFG_SIZE_W = 13;
	localparam int unsigned CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FORMAT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT       = 3'd5;

	// pixel layout codes; the unused code behaves as RGBA
	localparam logic [1:0] FMT_GRAY = 2'd0;
	localparam logic [1:0] FMT_BGRA = 2'd1;
	localparam logic [1:0] FMT_RGBA = 2'd2;

	// luma weights and divide-by-100 reciprocal (multiply, then shift)
	localparam int unsigned SUM_W      = 15;
	localparam int unsigned RECIP_100  = 5243;
	localparam int unsigned RECIP_W    = 13;
	localparam int unsigned RECIP_SH   = 19;
	localparam int unsigned QPROD_W    = SUM_W + RECIP_W;

	// queue depth between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// settled configuration, sizes already clamped to 1..MAX_DIMENSION
	typedef struct packed {
		logic [1:0]        source_format;
		logic [1:0]        target_format;
		logic              premultiply_enable;
		logic [SIZE_W-1:0] step;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} pxcd_cfg_t;

	// one kept pixel with its position flags
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic       row_last;
		logic       frame_last;
	} pxcd_item_t;

	// clamp a size register to 1..MAX_DIMENSION
	function automatic logic [SIZE_W-1:0] clamp_dim(input logic [CFG_SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		begin
			if (v == '0) begin
				r = SIZE_W'(1);
			end else if (32'(v) > MAX_DIMENSION) begin
				r = SIZE_W'(MAX_DIMENSION);
			end else begin
				r = SIZE_W'(v);
			end
			return r;
		end
	endfunction

endpackage

/* hw/rtl/pxcd_front.sv */
// front end: raster position tracking, decimation and row/frame end flags
module pxcd_front import pxcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pxcd_cfg_t  cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte0,
	input  logic [7:0] in_byte1,
	input  logic [7:0] in_byte2,
	input  logic [7:0] in_byte3,
	input  logic       queue_full,
	output logic       push,
	output pxcd_item_t push_item
);

	logic [DIM_W-1:0] column_count_q, row_count_q, column_phase_q, row_phase_q;
	logic [DIM_W-1:0] cc, rc, cp, rp;
	logic [DIM_W-1:0] cc_nxt, rc_nxt, cp_nxt, rp_nxt;
	logic             accept, keep, rlast, flast;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// wrap stale position, classify pixel, compute next position
	always_comb begin
		cc = column_count_q;
		cp = column_phase_q;
		rc = row_count_q;
		rp = row_phase_q;
		if ({1'b0, cc} >= cfg.width) begin
			cc = '0;
			cp = '0;
		end
		if ({1'b0, rc} >= cfg.height) begin
			rc = '0;
			rp = '0;
		end
		if ({1'b0, cp} >= cfg.step) cp = '0;
		if ({1'b0, rp} >= cfg.step) rp = '0;

		keep  = (cp == '0) && (rp == '0);
		rlast = ({2'b0, cc} + {1'b0, cfg.step}) >= {1'b0, cfg.width};
		flast = rlast && (({2'b0, rc} + {1'b0, cfg.step}) >= {1'b0, cfg.height});

		cc_nxt = cc;
		cp_nxt = cp;
		rc_nxt = rc;
		rp_nxt = rp;
		if (({1'b0, cc} + SIZE_W'(1)) >= cfg.width) begin
			cc_nxt = '0;
			cp_nxt = '0;
			if (({1'b0, rc} + SIZE_W'(1)) >= cfg.height) begin
				rc_nxt = '0;
				rp_nxt = '0;
			end else begin
				rc_nxt = rc + DIM_W'(1);
				rp_nxt = (({1'b0, rp} + SIZE_W'(1)) >= cfg.step) ? '0 : rp + DIM_W'(1);
			end
		end else begin
			cc_nxt = cc + DIM_W'(1);
			cp_nxt = (({1'b0, cp} + SIZE_W'(1)) >= cfg.step) ? '0 : cp + DIM_W'(1);
		end
	end

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			column_phase_q <= '0;
			row_phase_q    <= '0;
		end else if (accept) begin
			column_count_q <= cc_nxt;
			row_count_q    <= rc_nxt;
			column_phase_q <= cp_nxt;
			row_phase_q    <= rp_nxt;
		end
	end

	// kept pixels go to the queue
	assign push = accept && keep;
	always_comb begin
		push_item.byte0      = in_byte0;
		push_item.byte1      = in_byte1;
		push_item.byte2      = in_byte2;
		push_item.byte3      = in_byte3;
		push_item.row_last   = rlast;
		push_item.frame_last = flast;
	end

endmodule

/* hw/rtl/pxcd_queue.sv */
// small first-in first-out queue of kept pixels between front and back
module pxcd_queue import pxcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pxcd_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output pxcd_item_t head
);

	pxcd_item_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/pxcd_back.sv */
// back end: three-stage format conversion pipeline with output register
module pxcd_back import pxcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pxcd_cfg_t  cfg,
	input  logic       head_valid,
	input  pxcd_item_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic       row_last,
	output logic       frame_last
);

	logic              adv;
	logic              valid_s1, valid_s2, out_valid_q;
	logic [7:0]        r_u, g_u, b_u, a_u;
	logic [7:0]        r_s1, g_s1, b_s1, a_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic [15:0]       pr_s1, pg_s1, pb_s1;
	logic              rl_s1, fl_s1;
	logic [7:0]        r_s2, g_s2, b_s2, a_s2;
	logic [7:0]        sr_s2, sg_s2, sb_s2;
	logic [QPROD_W-1:0] qprod_s2;
	logic              rl_s2, fl_s2;
	logic [7:0]        gray;
	logic [15:0]       gray_a;
	logic [7:0]        r_c, g_c, b_c;
	logic [7:0]        o0, o1, o2, o3;
	logic [7:0]        out_byte0_q, out_byte1_q, out_byte2_q, out_byte3_q;
	logic              row_last_q, frame_last_q;

	// whole pipe moves unless the output item is held
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && head_valid;

	// unpack source layout
	always_comb begin
		if (cfg.source_format == FMT_GRAY) begin
			r_u = head.byte0;
			g_u = head.byte0;
			b_u = head.byte0;
			a_u = head.byte0;
		end else if (cfg.source_format == FMT_BGRA) begin
			b_u = head.byte0;
			g_u = head.byte1;
			r_u = head.byte2;
			a_u = head.byte3;
		end else begin
			r_u = head.byte0;
			g_u = head.byte1;
			b_u = head.byte2;
			a_u = head.byte3;
		end
	end

	// stage 1: weighted luma sum and alpha products
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1   <= r_u;
			g_s1   <= g_u;
			b_s1   <= b_u;
			a_s1   <= a_u;
			sum_s1 <= SUM_W'(SUM_W'(30) * SUM_W'(r_u)) + SUM_W'(SUM_W'(59) * SUM_W'(g_u))
				+ SUM_W'(SUM_W'(11) * SUM_W'(b_u));
			pr_s1  <= 16'(r_u) * 16'(a_u);
			pg_s1  <= 16'(g_u) * 16'(a_u);
			pb_s1  <= 16'(b_u) * 16'(a_u);
			rl_s1  <= head.row_last;
			fl_s1  <= head.frame_last;
		end
	end

	// stage 2: divide the sum by 100 through its reciprocal
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2     <= r_s1;
			g_s2     <= g_s1;
			b_s2     <= b_s1;
			a_s2     <= a_s1;
			sr_s2    <= pr_s1[15:8];
			sg_s2    <= pg_s1[15:8];
			sb_s2    <= pb_s1[15:8];
			qprod_s2 <= QPROD_W'(sum_s1) * QPROD_W'(RECIP_100);
			rl_s2    <= rl_s1;
			fl_s2    <= fl_s1;
		end
	end

	// stage 3: alpha-scaled gray (source byte for a gray source), premultiply choice and target layout selection
	always_comb begin
		gray   = qprod_s2[RECIP_SH +: 8];
		gray_a = 16'(gray) * 16'(a_s2);
		r_c    = cfg.premultiply_enable ? sr_s2 : r_s2;
		g_c    = cfg.premultiply_enable ? sg_s2 : g_s2;
		b_c    = cfg.premultiply_enable ? sb_s2 : b_s2;
		if (cfg.target_format == FMT_GRAY) begin
			o0 = (cfg.source_format == FMT_GRAY) ? r_s2 : gray_a[15:8];
			o1 = '0;
			o2 = '0;
			o3 = '0;
		end else if (cfg.target_format == FMT_BGRA) begin
			o0 = b_c;
			o1 = g_c;
			o2 = r_c;
			o3 = a_s2;
		end else begin
			o0 = r_c;
			o1 = g_c;
			o2 = b_c;
			o3 = a_s2;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte0_q  <= o0;
			out_byte1_q  <= o1;
			out_byte2_q  <= o2;
			out_byte3_q  <= o3;
			row_last_q   <= rl_s2;
			frame_last_q <= fl_s2;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte0  = out_byte0_q;
	assign out_byte1  = out_byte1_q;
	assign out_byte2  = out_byte2_q;
	assign out_byte3  = out_byte3_q;
	assign row_last   = row_last_q;
	assign frame_last = frame_last_q;

endmodule

/* hw/rtl/pixel_format_converter_decimator.sv */
// Pixel format converter and decimator. Source pixels enter in raster order, one item per
// cycle when the queue has room; a pixel is kept when its row and column are multiples of
// sample_step and is converted from the source layout (gray, BGRA, RGBA) to the target
// layout, with optional alpha premultiply. Sustained rate is one pixel per clock while
// out_stall stays low; a kept pixel is written into the queue at acceptance, then passes
// two arithmetic stages and the output register on its way out. A four-entry queue
// decouples the position tracker from the conversion pipeline, so in_stall rises only when
// that queue is full; the whole conversion pipeline holds while out_stall keeps an item
// waiting. Configuration writes are always taken (cfg_ready is high) and must be made while
// no item is in flight.
module pixel_format_converter_decimator import pxcd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_SIZE_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte0,
	input  logic [7:0]            in_byte1,
	input  logic [7:0]            in_byte2,
	input  logic [7:0]            in_byte3,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte0,
	output logic [7:0]            out_byte1,
	output logic [7:0]            out_byte2,
	output logic [7:0]            out_byte3,
	output logic                  row_last,
	output logic                  frame_last
);

	logic [1:0]            source_format_q, target_format_q;
	logic                  premultiply_enable_q;
	logic [CFG_SIZE_W-1:0] sample_step_q, frame_width_q, frame_height_q;
	pxcd_cfg_t             cfg;
	logic                  push, queue_full, pop, head_valid;
	pxcd_item_t            push_item, head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q      <= FMT_RGBA;
			target_format_q      <= FMT_RGBA;
			premultiply_enable_q <= 1'b0;
			sample_step_q        <= CFG_SIZE_W'(1);
			frame_width_q        <= CFG_SIZE_W'(1);
			frame_height_q       <= CFG_SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE_FORMAT:      source_format_q      <= cfg_data[1:0];
				REG_TARGET_FORMAT:      target_format_q      <= cfg_data[1:0];
				REG_PREMULTIPLY_ENABLE: premultiply_enable_q <= cfg_data[0];
				REG_SAMPLE_STEP:        sample_step_q        <= cfg_data;
				REG_FRAME_WIDTH:        frame_width_q        <= cfg_data;
				REG_FRAME_HEIGHT:       frame_height_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// settled view of the registers
	always_comb begin
		cfg.source_format      = source_format_q;
		cfg.target_format      = target_format_q;
		cfg.premultiply_enable = premultiply_enable_q;
		cfg.step               = clamp_dim(sample_step_q);
		cfg.width              = clamp_dim(frame_width_q);
		cfg.height             = clamp_dim(frame_height_q);
	end

	pxcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte0   (in_byte0),
		.in_byte1   (in_byte1),
		.in_byte2   (in_byte2),
		.in_byte3   (in_byte3),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	pxcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (head_valid),
		.head      (head)
	);

	pxcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte0  (out_byte0),
		.out_byte1  (out_byte1),
		.out_byte2  (out_byte2),
		.out_byte3  (out_byte3),
		.row_last   (row_last),
		.frame_last (frame_last)
	);

endmodule
